[src/wkmp_pkg.sv]
// shared types, constants and helpers for the wildcard kmp match counter
package wkmp_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int BYTE_W = 8;
	localparam int PAT_W = MAX_PATTERN * BYTE_W;
	localparam int LEN_W = 4;
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int POS_W = $clog2(MAX_PATTERN + 1);
	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = PAT_W;

	localparam logic [BYTE_W-1:0] WILDCARD = 8'h2A;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic             match_found;
		logic [CNT_W-1:0] match_count;
		logic             text_done;
	} out_item_t;

	typedef enum logic {
		MS_IDLE,
		MS_RUN
	} match_state_t;

	// builder status seen by the matcher
	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] final_border;
		logic [IDX_W-1:0] rd_data;
	} bld_status_t;

	function automatic logic [POS_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [POS_W-1:0] res;
		if (len == '0) begin
			res = POS_W'(1);
		end else if (32'(len) > MAX_PATTERN) begin
			res = POS_W'(MAX_PATTERN);
		end else begin
			res = POS_W'(len);
		end
		return res;
	endfunction

	function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pattern,
			input logic [IDX_W-1:0] k);
		return pattern[BYTE_W*k +: BYTE_W];
	endfunction

endpackage

[src/wildcard_kmp_match_counter_core.sv]
// top level of the wildcard kmp match counter: config registers, builder and matcher
//
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_item (text_byte, last_byte)
// out      output     out_valid/out_stall out_item (match_found, match_count, text_done)
// cfg      input      cfg_we              cfg_idx, cfg_data
//
// after a byte is accepted, it gets one compare or border fallback per cycle
// in the shared compare unit of the matcher
// a write to the pattern or length register rebuilds the border table, one
// step a cycle, and input stalls meanwhile
// reset clears position, count and table (the reset pattern has an all-zero table)
// a result waits in the output register; the next byte is taken meanwhile and
// its last step holds until the register is free
module wildcard_kmp_match_counter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  wkmp_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output wkmp_pkg::out_item_t             out_item,
	input  logic                            cfg_we,
	input  logic [wkmp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [wkmp_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [wkmp_pkg::PAT_W-1:0] pattern_q;
	logic [wkmp_pkg::LEN_W-1:0] length_q;
	logic                       cfg_hit;
	logic [wkmp_pkg::POS_W-1:0] m;
	logic [wkmp_pkg::IDX_W-1:0] rd_idx;
	wkmp_pkg::bld_status_t      bld_st;

	assign cfg_hit = cfg_we && ((cfg_idx == wkmp_pkg::REG_PATTERN_BYTES) ||
		(cfg_idx == wkmp_pkg::REG_PATTERN_LENGTH));
	assign m = wkmp_pkg::eff_len(length_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= wkmp_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			if (cfg_idx == wkmp_pkg::REG_PATTERN_BYTES) begin
				pattern_q <= cfg_data[wkmp_pkg::PAT_W-1:0];
			end
			if (cfg_idx == wkmp_pkg::REG_PATTERN_LENGTH) begin
				length_q <= cfg_data[wkmp_pkg::LEN_W-1:0];
			end
		end
	end

	wkmp_border u_border (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_hit),
		.pattern (pattern_q),
		.m       (m),
		.rd_idx  (rd_idx),
		.status  (bld_st)
	);

	wkmp_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_hit   (cfg_hit),
		.cfg_we    (cfg_we),
		.pattern   (pattern_q),
		.m         (m),
		.bld       (bld_st),
		.rd_idx    (rd_idx),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// no byte enters while the border table is rebuilt
	a_stall_while_building: assert property (@(posedge clk) disable iff (!arst_n)
		bld_st.busy |-> in_stall)
		else $error("byte accepted during table rebuild");

	a_rebuild_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> bld_st.busy)
		else $error("register write did not start a rebuild");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second byte accepted while one is in work");

	a_match_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.match_found) |-> (out_item.match_count != '0))
		else $error("match reported with zero count");

endmodule

[src/wkmp_border.sv]
// border table builder: one kmp prefix-function step per cycle after a register write
module wkmp_border (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wkmp_pkg::PAT_W-1:0]    pattern,
	input  logic [wkmp_pkg::POS_W-1:0]    m,
	input  logic [wkmp_pkg::IDX_W-1:0]    rd_idx,
	output wkmp_pkg::bld_status_t         status
);

	logic [wkmp_pkg::IDX_W-1:0] table_q [wkmp_pkg::MAX_PATTERN];
	logic [wkmp_pkg::IDX_W-1:0] final_q;
	logic                       busy_q;
	logic [wkmp_pkg::POS_W-1:0] i_q;
	logic [wkmp_pkg::IDX_W-1:0] len_q;

	logic [wkmp_pkg::IDX_W-1:0] addr;
	logic [wkmp_pkg::IDX_W-1:0] rd_val;
	logic                       eq;
	logic                       done;
	logic                       is_last;
	logic [wkmp_pkg::IDX_W-1:0] len_inc;

	// single read port, owned by the builder while it runs
	assign addr    = busy_q ? (len_q - wkmp_pkg::IDX_W'(1)) : rd_idx;
	assign rd_val  = table_q[addr];
	assign done    = (i_q >= m);
	assign eq      = (wkmp_pkg::pat_byte(pattern, i_q[wkmp_pkg::IDX_W-1:0]) ==
		wkmp_pkg::pat_byte(pattern, len_q));
	assign is_last = (i_q == (m - wkmp_pkg::POS_W'(1)));
	assign len_inc = len_q + wkmp_pkg::IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			i_q     <= '0;
			len_q   <= '0;
			final_q <= '0;
			for (int k = 0; k < wkmp_pkg::MAX_PATTERN; k++) begin
				table_q[k] <= '0;
			end
		end else if (start) begin
			busy_q  <= 1'b1;
			i_q     <= wkmp_pkg::POS_W'(1);
			len_q   <= '0;
			final_q <= '0;
			for (int k = 0; k < wkmp_pkg::MAX_PATTERN; k++) begin
				table_q[k] <= '0;
			end
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end else if (eq) begin
				table_q[i_q[wkmp_pkg::IDX_W-1:0]] <= len_inc;
				if (is_last) begin
					final_q <= len_inc;
				end
				len_q <= len_inc;
				i_q   <= i_q + wkmp_pkg::POS_W'(1);
			end else if (len_q != '0) begin
				// fall back to the border of the current border
				len_q <= rd_val;
			end else begin
				table_q[i_q[wkmp_pkg::IDX_W-1:0]] <= '0;
				if (is_last) begin
					final_q <= '0;
				end
				i_q <= i_q + wkmp_pkg::POS_W'(1);
			end
		end
	end

	assign status.busy         = busy_q;
	assign status.final_border = final_q;
	assign status.rd_data      = rd_val;

endmodule

[src/wkmp_match.sv]
// matcher: one compare/fallback step per cycle per byte, held by out_stall
module wkmp_match (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_hit,
	input  logic                        cfg_we,
	input  logic [wkmp_pkg::PAT_W-1:0]  pattern,
	input  logic [wkmp_pkg::POS_W-1:0]  m,
	input  wkmp_pkg::bld_status_t       bld,
	output logic [wkmp_pkg::IDX_W-1:0]  rd_idx,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  wkmp_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output wkmp_pkg::out_item_t         out_item
);

	wkmp_pkg::match_state_t state_q, state_d;
	wkmp_pkg::in_item_t     item_q;
	wkmp_pkg::out_item_t    out_item_q;
	logic                   out_valid_q;
	logic [wkmp_pkg::POS_W-1:0] j_q, j_d;
	logic [wkmp_pkg::CNT_W-1:0] cnt_q, cnt_d;

	logic                        accept;
	logic                        slot_free;
	logic                        commit;
	logic                        hit;
	logic                        found;
	logic [wkmp_pkg::BYTE_W-1:0] p;
	logic [wkmp_pkg::POS_W-1:0]  j_inc;
	logic [wkmp_pkg::POS_W-1:0]  j_end;
	logic [wkmp_pkg::CNT_W-1:0]  cnt_new;

	assign in_stall  = (state_q != wkmp_pkg::MS_IDLE) || bld.busy || cfg_we;
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// shared compare unit
	assign p     = wkmp_pkg::pat_byte(pattern, j_q[wkmp_pkg::IDX_W-1:0]);
	assign hit   = (p == item_q.text_byte) || (p == wkmp_pkg::WILDCARD);
	assign j_inc = j_q + wkmp_pkg::POS_W'(1);
	assign found = hit && (j_inc >= m);
	assign j_end = found ? wkmp_pkg::POS_W'(bld.final_border) : (hit ? j_inc : '0);
	assign rd_idx = j_q[wkmp_pkg::IDX_W-1:0] - wkmp_pkg::IDX_W'(1);
	assign cnt_new = (found && cnt_q != wkmp_pkg::COUNT_MAX) ?
		cnt_q + wkmp_pkg::CNT_W'(1) : cnt_q;

	always_comb begin
		state_d = state_q;
		j_d     = j_q;
		cnt_d   = cnt_q;
		commit  = 1'b0;
		unique case (state_q)
			wkmp_pkg::MS_IDLE: begin
				if (cfg_hit) begin
					j_d = '0;
				end else if (accept) begin
					state_d = wkmp_pkg::MS_RUN;
					if (j_q >= m) begin
						j_d = '0;
					end
				end
			end
			wkmp_pkg::MS_RUN: begin
				if (hit || j_q == '0) begin
					// final step, held until the output slot is free
					if (slot_free) begin
						commit  = 1'b1;
						state_d = wkmp_pkg::MS_IDLE;
						j_d     = item_q.last_byte ? '0 : j_end;
						cnt_d   = item_q.last_byte ? '0 : cnt_new;
					end
				end else begin
					j_d = wkmp_pkg::POS_W'(bld.rd_data);
				end
			end
			default: begin
				state_d = wkmp_pkg::MS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wkmp_pkg::MS_IDLE;
			j_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			cnt_q   <= cnt_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		if (commit) begin
			out_item_q.match_found <= found;
			out_item_q.match_count <= cnt_new;
			out_item_q.text_done   <= item_q.last_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[tb/sv/wkmp_result_checker.sv]
// result checker for the wildcard kmp match counter: predicts each byte's result and compares
module wkmp_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  wkmp_pkg::in_item_t              in_item,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  wkmp_pkg::out_item_t             out_item,
	input  logic                            cfg_we,
	input  logic [wkmp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [wkmp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatch_count,
	output int                              pending
);

	typedef logic [wkmp_pkg::MAX_PATTERN-1:0][wkmp_pkg::IDX_W-1:0] border_row_t;

	logic [wkmp_pkg::PAT_W-1:0] pat_reg;
	logic [wkmp_pkg::LEN_W-1:0] len_reg;
	border_row_t                border;
	int                         prefix;
	logic [wkmp_pkg::CNT_W-1:0] count;
	wkmp_pkg::out_item_t        predicted_out[$];

	// out-of-range lengths clamp to 1..MAX_PATTERN
	function automatic int active_len(input logic [wkmp_pkg::LEN_W-1:0] len);
		if (len == '0) begin
			return 1;
		end
		if (32'(len) > wkmp_pkg::MAX_PATTERN) begin
			return wkmp_pkg::MAX_PATTERN;
		end
		return int'(len);
	endfunction

	// literal byte compare here, so the wildcard is an ordinary byte for the table
	function automatic border_row_t build_borders(input logic [wkmp_pkg::PAT_W-1:0] pat,
			input int m);
		border_row_t tbl;
		int k;
		int i;
		tbl = '0;
		k = 0;
		i = 1;
		while (i < m) begin
			if (pat[wkmp_pkg::BYTE_W*i +: wkmp_pkg::BYTE_W] ==
					pat[wkmp_pkg::BYTE_W*k +: wkmp_pkg::BYTE_W]) begin
				k++;
				tbl[i] = wkmp_pkg::IDX_W'(k);
				i++;
			end else if (k != 0) begin
				k = int'(tbl[k-1]);
			end else begin
				i++;
			end
		end
		return tbl;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int m;
		int j;
		logic hit;
		logic stop;
		logic [wkmp_pkg::BYTE_W-1:0] p;
		wkmp_pkg::out_item_t want;
		wkmp_pkg::out_item_t got;
		if (!arst_n) begin
			pat_reg = '0;
			len_reg = wkmp_pkg::LEN_W'(1);
			prefix = 0;
			count = '0;
			border = build_borders('0, 1);
			predicted_out.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_we && (cfg_idx == wkmp_pkg::REG_PATTERN_BYTES ||
					cfg_idx == wkmp_pkg::REG_PATTERN_LENGTH)) begin
				if (cfg_idx == wkmp_pkg::REG_PATTERN_BYTES) begin
					pat_reg = cfg_data[wkmp_pkg::PAT_W-1:0];
				end else begin
					len_reg = cfg_data[wkmp_pkg::LEN_W-1:0];
				end
				// count survives a register write, the partial match does not
				prefix = 0;
				border = build_borders(pat_reg, active_len(len_reg));
			end

			if (in_valid && !in_stall) begin
				m = active_len(len_reg);
				j = (prefix >= m) ? 0 : prefix;
				hit = 1'b0;
				stop = 1'b0;
				while (!stop) begin
					p = pat_reg[wkmp_pkg::BYTE_W*j +: wkmp_pkg::BYTE_W];
					if (p == in_item.text_byte || p == wkmp_pkg::WILDCARD) begin
						j++;
						if (j >= m) begin
							hit = 1'b1;
							if (count != wkmp_pkg::COUNT_MAX) begin
								count++;
							end
							j = int'(border[m-1]);
						end
						stop = 1'b1;
					end else if (j == 0) begin
						stop = 1'b1;
					end else begin
						j = int'(border[j-1]);
					end
				end
				prefix = j;
				want.match_found = hit;
				want.match_count = count;
				want.text_done = in_item.last_byte;
				predicted_out.push_back(want);
				// end of text clears after its result is formed
				if (in_item.last_byte) begin
					prefix = 0;
					count = '0;
				end
			end

			if (out_valid && !out_stall) begin
				got = out_item;
				if (predicted_out.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("unexpected result transaction: found=%0d count=%0d done=%0d",
							got.match_found, got.match_count, got.text_done);
					end
				end else begin
					want = predicted_out.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("result mismatch (found/count/done): expected %0d/%0d/%0d",
								want.match_found, want.match_count, want.text_done);
							$display("  got %0d/%0d/%0d",
								got.match_found, got.match_count, got.text_done);
						end
					end
				end
			end
		end
		pending = predicted_out.size();
	end

endmodule

[tb/sv/wildcard_kmp_match_counter_core_tb.sv]
// testbench top for the wildcard kmp match counter: stimulus, stalls and verdict
module wildcard_kmp_match_counter_core_tb;

	localparam int RANDOM_ITEMS = 1450;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam logic [wkmp_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [wkmp_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	wkmp_pkg::in_item_t              in_item;
	logic                            out_valid;
	logic                            out_stall;
	wkmp_pkg::out_item_t             out_item;
	logic                            cfg_we;
	logic [wkmp_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [wkmp_pkg::CFG_DATA_W-1:0] cfg_data;

	int          mismatch_count;
	int          pending;
	logic        quiet = 1'b0;
	logic        out_took = 1'b0;
	int          rx_wait;
	int          sent = 0;
	int unsigned cycle_cnt;

	wildcard_kmp_match_counter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	wkmp_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** wildcard_kmp_match_counter_core: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		out_took <= out_valid && !out_stall;
	end

	// receiver: after each result transaction, hold stall for a drawn number of cycles
	initial begin
		out_stall = 1'b0;
		rx_wait = 0;
		forever begin
			@(negedge clk);
			if (out_took) begin
				rx_wait = quiet ? 0 : $urandom_range(0, 6);
			end
			if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [wkmp_pkg::BYTE_W-1:0] b, input logic lst);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{text_byte: b, last_byte: lst};
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// sender holds off until every predicted result has been taken
	task automatic wait_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [wkmp_pkg::CFG_IDX_W-1:0] idx,
			input logic [wkmp_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [wkmp_pkg::BYTE_W-1:0]     sym[3];
		logic [wkmp_pkg::PAT_W-1:0]      pat;
		logic [wkmp_pkg::PAT_W-1:0]      cand;
		logic [wkmp_pkg::LEN_W-1:0]      len;
		logic [wkmp_pkg::CFG_DATA_W-1:0] cfg_word;
		logic [wkmp_pkg::BYTE_W-1:0]     b;
		logic [wkmp_pkg::BYTE_W-1:0]     text[$];
		logic                            open_end;
		int                              tlen;
		int                              copy_len;
		int                              ntexts;
		int                              n;
		int                              k;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset pattern: a single 0x00 byte
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(wkmp_pkg::WILDCARD, 1'b0);
		send_byte(8'h00, 1'b1);

		// "a*a" with junk above the length, overlapping hits
		wait_results();
		write_reg(wkmp_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FF61_2A61);
		write_reg(wkmp_pkg::REG_PATTERN_LENGTH, wkmp_pkg::CFG_DATA_W'(3));
		send_byte(8'h61, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(wkmp_pkg::WILDCARD, 1'b0);
		send_byte(8'h61, 1'b1);

		// write in the middle of a text keeps the count; length zero acts as one
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		wait_results();
		write_reg(wkmp_pkg::REG_PATTERN_LENGTH, '0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b1);

		// unused indexes are ignored; length above max acts as max
		wait_results();
		write_reg(REG_UNUSED_2, {$urandom, $urandom});
		write_reg(REG_UNUSED_3, {$urandom, $urandom});
		pat = {wkmp_pkg::MAX_PATTERN{wkmp_pkg::WILDCARD}};
		write_reg(wkmp_pkg::REG_PATTERN_BYTES, pat);
		write_reg(wkmp_pkg::REG_PATTERN_LENGTH,
			{{(wkmp_pkg::CFG_DATA_W-wkmp_pkg::LEN_W){1'b1}}, {wkmp_pkg::LEN_W{1'b1}}});
		for (k = 0; k < wkmp_pkg::MAX_PATTERN; k++) begin
			send_byte((k % 2 == 0) ? 8'h00 : 8'hFF, k == wkmp_pkg::MAX_PATTERN - 1);
		end

		while (sent < RANDOM_ITEMS + 25) begin
			wait_results();
			quiet = ($urandom_range(0, 3) == 0);
			sym[0] = 8'($urandom_range(0, 255));
			sym[1] = 8'($urandom_range(0, 255));
			sym[2] = ($urandom_range(0, 2) == 0) ? wkmp_pkg::WILDCARD :
				8'($urandom_range(0, 255));
			if ($urandom_range(0, 3) == 0) begin
				cand = {$urandom, $urandom};
			end else begin
				for (k = 0; k < wkmp_pkg::MAX_PATTERN; k++) begin
					cand[wkmp_pkg::BYTE_W*k +: wkmp_pkg::BYTE_W] =
						($urandom_range(0, 4) == 0) ? wkmp_pkg::WILDCARD :
						sym[$urandom_range(0, 2)];
				end
			end
			if ($urandom_range(0, 7) == 0) begin
				len = ($urandom_range(0, 1) == 0) ? '0 :
					wkmp_pkg::LEN_W'($urandom_range(9, 15));
			end else begin
				len = wkmp_pkg::LEN_W'($urandom_range(1, wkmp_pkg::MAX_PATTERN));
			end
			cfg_word = {$urandom, $urandom};
			cfg_word[wkmp_pkg::LEN_W-1:0] = len;
			case ($urandom_range(0, 3))
				0: begin
					pat = cand;
					write_reg(wkmp_pkg::REG_PATTERN_BYTES, pat);
					write_reg(wkmp_pkg::REG_PATTERN_LENGTH, cfg_word);
				end
				1: begin
					pat = cand;
					write_reg(wkmp_pkg::REG_PATTERN_LENGTH, cfg_word);
					write_reg(wkmp_pkg::REG_PATTERN_BYTES, pat);
				end
				2: begin
					pat = cand;
					write_reg(wkmp_pkg::REG_PATTERN_BYTES, pat);
				end
				default: begin
					write_reg(wkmp_pkg::REG_PATTERN_LENGTH, cfg_word);
				end
			endcase
			if ($urandom_range(0, 5) == 0) begin
				write_reg(($urandom_range(0, 1) == 0) ? REG_UNUSED_2 : REG_UNUSED_3,
					{$urandom, $urandom});
			end

			open_end = ($urandom_range(0, 3) == 0);
			ntexts = $urandom_range(1, 4);
			for (n = 0; n < ntexts; n++) begin
				tlen = $urandom_range(1, 30);
				text.delete();
				while (text.size() < tlen) begin
					case ($urandom_range(0, 3))
						0, 1: text.push_back(sym[$urandom_range(0, 2)]);
						2: begin
							// partial or full pattern copy, wildcard spots filled at random
							copy_len = $urandom_range(1, wkmp_pkg::MAX_PATTERN);
							for (k = 0; k < copy_len; k++) begin
								b = pat[wkmp_pkg::BYTE_W*k +: wkmp_pkg::BYTE_W];
								if (b == wkmp_pkg::WILDCARD) begin
									b = 8'($urandom_range(0, 255));
								end
								text.push_back(b);
							end
						end
						default: text.push_back(8'($urandom_range(0, 255)));
					endcase
				end
				for (k = 0; k < text.size(); k++) begin
					if ($urandom_range(0, 59) == 0) begin
						wait_results();
					end
					send_byte(text[k], (k == text.size() - 1) && !(n == ntexts - 1 && open_end));
				end
			end
		end

		wait_results();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && pending == 0) begin
			$display("** wildcard_kmp_match_counter_core: PASSED **");
		end else begin
			$display("** wildcard_kmp_match_counter_core: FAILED **");
		end
		$finish;
	end

endmodule
